@@ design/assert_macros.svh @@
// Assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(lbl, clk, rstn, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rstn, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("lbl");
`endif

@@ design/c2s_pkg.sv @@
// Shared constants and functions for the Cartesian to spherical converter
`timescale 1ns / 1ps
`default_nettype none
package c2s_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF = 20;
    localparam int COMP_W = 24;
    localparam int ANG_W = 25;
    localparam int GUARD = 30;
    // CORDIC datapath width: 24-bit operand, 30 guard bits, growth and sign
    localparam int CW = 58;
    localparam int AW = 43;
    // square of 24-bit values summed over three terms
    localparam int SQ_W = 50;
    localparam int ROOT_W = 25;
    localparam int DIV_W = 48;

    // atan(2^-i) in degrees, Q32, from the odd power series
    function automatic logic signed [AW-1:0] stage_angle(input int i);
        logic [63:0] k52;
        logic signed [63:0] acc;
        logic signed [63:0] term;
        int sh;
        k52 = 64'd246083499207 << 20;
        acc = '0;
        if (i == 0)
        begin
            acc = 64'sd45 <<< 32;
            return acc[AW-1:0];
        end
        for (int k = 0; k < 32; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh < 60)
            begin
                term = $signed(64'(k52 >> sh) / 64'(2 * k + 1));
                acc = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        acc = (acc + (64'sd1 <<< 19)) >>> 20;
        return acc[AW-1:0];
    endfunction
endpackage
`default_nettype wire

@@ design/c2s_root_cell.sv @@
// One step of the shift-subtract square root with rounding at the last cell
`timescale 1ns / 1ps
`default_nettype none
module c2s_root_cell #(
    parameter int STEP = 0,
    parameter int LAST = 0
) (
    input  wire logic                     clk,
    input  wire logic [c2s_pkg::SQ_W-1:0] s_in,
    input  wire logic [c2s_pkg::SQ_W-1:0] r_in,
    output logic      [c2s_pkg::SQ_W-1:0] s_out,
    output logic      [c2s_pkg::SQ_W-1:0] r_out
);
    localparam int BPOS = c2s_pkg::SQ_W - 2 - 2 * STEP;
    localparam logic [c2s_pkg::SQ_W-1:0] BIT = c2s_pkg::SQ_W'(1) << BPOS;
    logic [c2s_pkg::SQ_W-1:0] s_next, r_next, rb;

    always_comb
    begin
        rb = r_in + BIT;
        if (s_in >= rb)
        begin
            s_next = s_in - rb;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            s_next = s_in;
            r_next = r_in >> 1;
        end
        // round up when the remainder exceeds the root
        if (LAST != 0 && s_next > r_next)
            r_next = r_next + c2s_pkg::SQ_W'(1);
    end

    always_ff @(posedge clk)
    begin
        s_out <= s_next;
        r_out <= r_next;
    end
endmodule
`default_nettype wire

@@ design/c2s_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with angle accumulation
`timescale 1ns / 1ps
`default_nettype none
module c2s_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                            clk,
    input  wire logic signed [c2s_pkg::CW-1:0]   x_in,
    input  wire logic signed [c2s_pkg::CW-1:0]   y_in,
    input  wire logic signed [c2s_pkg::AW-1:0]   a_in,
    output logic signed      [c2s_pkg::CW-1:0]   x_out,
    output logic signed      [c2s_pkg::CW-1:0]   y_out,
    output logic signed      [c2s_pkg::AW-1:0]   a_out
);
    localparam logic signed [c2s_pkg::AW-1:0] ANG = c2s_pkg::stage_angle(STAGE);
    logic signed [c2s_pkg::CW-1:0] dx, dy;

    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;

    always_ff @(posedge clk)
    begin
        if (y_in > 0)
        begin
            x_out <= x_in + dx;
            y_out <= y_in - dy;
            a_out <= a_in + ANG;
        end
        else
        begin
            x_out <= x_in - dx;
            y_out <= y_in + dy;
            a_out <= a_in - ANG;
        end
    end
endmodule
`default_nettype wire

@@ design/c2s_div_cell.sv @@
// One restoring division step for the three normalized components
`timescale 1ns / 1ps
`default_nettype none
module c2s_div_cell #(
    parameter int STEP = 0
) (
    input  wire logic                      clk,
    input  wire logic [c2s_pkg::DIV_W-1:0] rem_in [3],
    input  wire logic [c2s_pkg::DIV_W-1:0] quo_in [3],
    input  wire logic [c2s_pkg::DIV_W-1:0] den,
    output logic      [c2s_pkg::DIV_W-1:0] rem_out [3],
    output logic      [c2s_pkg::DIV_W-1:0] quo_out [3]
);
    localparam int SH = c2s_pkg::DIV_W - 1 - STEP;
    logic [2*c2s_pkg::DIV_W-1:0] dsh;
    assign dsh = {{c2s_pkg::DIV_W{1'b0}}, den} << SH;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ({{c2s_pkg::DIV_W{1'b0}}, rem_in[k]} >= dsh)
            begin
                rem_out[k] <= rem_in[k] - dsh[c2s_pkg::DIV_W-1:0];
                quo_out[k] <= quo_in[k] | (c2s_pkg::DIV_W'(1) << SH);
            end
            else
            begin
                rem_out[k] <= rem_in[k];
                quo_out[k] <= quo_in[k];
            end
        end
    end
endmodule
`default_nettype wire

@@ design/cartesian_to_spherical_deg_top.sv @@
// Top level of the pipelined Cartesian to spherical converter
//
// Usage: drive vec_x, vec_y, vec_z and normalize with start high. busy is
// always low, so a transaction is accepted at every edge where start is high,
// one per clock. Each transaction produces exactly one result, shown for one
// cycle with done high, in input order.
// The pipeline is 25 root cells, then the CORDIC chains of CORDIC_STAGES
// cells for both angles, then 48 division cells, plus an input register
// and an output register. The declination CORDIC waits on the planar root,
// which sets the depth; right ascension runs its own CORDIC chain beside it
// and all other fields ride delay registers alongside.
// Throughput is one vector per cycle: every cell is a pipeline stage.
// Reset clears only the valid chain and done; payload flows without reset. The
// receiver cannot stall, so done and the result ports are never held.
`timescale 1ns / 1ps
`default_nettype none
module cartesian_to_spherical_deg_top #(
    parameter int FRAC_BITS = c2s_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [23:0] vec_x,
    input  wire logic signed [23:0] vec_y,
    input  wire logic signed [23:0] vec_z,
    input  wire logic               normalize,
    output logic                    done,
    output logic signed [23:0]      out_x,
    output logic signed [23:0]      out_y,
    output logic signed [23:0]      out_z,
    output logic        [23:0]      magnitude,
    output logic signed [24:0]      right_ascension,
    output logic signed [23:0]      declination
);
    localparam int SW = c2s_pkg::SQ_W;
    localparam int CW = c2s_pkg::CW;
    localparam int AW = c2s_pkg::AW;
    localparam int DW = c2s_pkg::DIV_W;
    localparam int NR = c2s_pkg::ROOT_W;
    localparam int LAT = 1 + NR + CORDIC_STAGES + DW;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               norm;
    } item_t;

    assign busy = 1'b0;

    // valid chain
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    // input register and squares
    item_t in_reg;
    logic [SW-1:0] sxy_reg, sz_reg;
    always_ff @(posedge clk)
    begin
        in_reg  <= '{vec_x, vec_y, vec_z, normalize};
        sxy_reg <= SW'(vec_x * vec_x) + SW'(vec_y * vec_y);
        sz_reg  <= SW'(vec_z * vec_z);
    end

    // two root chains: planar and full
    logic [SW-1:0] sa [NR+1], ra [NR+1], sb [NR+1], rb [NR+1];
    assign sa[0] = sxy_reg;
    assign ra[0] = '0;
    assign sb[0] = sxy_reg + sz_reg;
    assign rb[0] = '0;
    item_t rd [NR+1];
    assign rd[0] = in_reg;

    for (genvar g = 0; g < NR; g++)
    begin : g_root
        c2s_root_cell #(.STEP(g), .LAST(g == NR - 1)) u_a (
            .clk(clk), .s_in(sa[g]), .r_in(ra[g]), .s_out(sa[g+1]), .r_out(ra[g+1]));
        c2s_root_cell #(.STEP(g), .LAST(g == NR - 1)) u_b (
            .clk(clk), .s_in(sb[g]), .r_in(rb[g]), .s_out(sb[g+1]), .r_out(rb[g+1]));
        always_ff @(posedge clk)
            rd[g+1] <= rd[g];
    end

    // CORDIC preparation for both angles
    typedef struct packed {
        logic       spec;
        logic signed [AW-1:0] sval;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] a;
    } prep_t;

    function automatic prep_t prep(input logic signed [25:0] num,
                                   input logic signed [25:0] den);
        prep_t p;
        logic signed [25:0] n, d;
        p = '0;
        n = num;
        d = den;
        if (num == 0)
        begin
            p.spec = 1'b1;
            p.sval = (den < 0) ? (AW'(180) <<< 32) : '0;
        end
        else if (den == 0)
        begin
            p.spec = 1'b1;
            p.sval = (num > 0) ? (AW'(90) <<< 32) : -(AW'(90) <<< 32);
        end
        else
        begin
            if (den < 0)
            begin
                if (num > 0)
                begin
                    d = num; n = -den; p.a = AW'(90) <<< 32;
                end
                else
                begin
                    d = -num; n = den; p.a = -(AW'(90) <<< 32);
                end
            end
            p.x = CW'(d) <<< c2s_pkg::GUARD;
            p.y = CW'(n) <<< c2s_pkg::GUARD;
        end
        return p;
    endfunction

    function automatic logic signed [24:0] to_frac(input logic signed [AW-1:0] a,
                                                   input int lim_deg);
        logic signed [AW-1:0] v, lim;
        v = (a + $signed(AW'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
        lim = AW'(lim_deg) <<< FRAC_BITS;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[24:0];
    endfunction

    prep_t pra, prd;
    always_comb
    begin
        pra = prep(26'(rd[NR].y), 26'(rd[NR].x));
        prd = prep(26'(rd[NR].z), $signed({1'b0, ra[NR][24:0]}));
    end

    logic signed [CW-1:0] xa [CORDIC_STAGES+1], ya [CORDIC_STAGES+1];
    logic signed [CW-1:0] xd [CORDIC_STAGES+1], yd [CORDIC_STAGES+1];
    logic signed [AW-1:0] aa [CORDIC_STAGES+1], ad [CORDIC_STAGES+1];
    logic spa [CORDIC_STAGES+1], spd [CORDIC_STAGES+1];
    logic signed [AW-1:0] sva [CORDIC_STAGES+1], svd [CORDIC_STAGES+1];
    item_t cd [CORDIC_STAGES+1];
    logic [23:0] mg [CORDIC_STAGES+1];

    assign xa[0] = pra.x; assign ya[0] = pra.y; assign aa[0] = pra.a;
    assign xd[0] = prd.x; assign yd[0] = prd.y; assign ad[0] = prd.a;
    assign spa[0] = pra.spec; assign sva[0] = pra.sval;
    assign spd[0] = prd.spec; assign svd[0] = prd.sval;
    assign cd[0] = rd[NR];
    assign mg[0] = (rb[NR] > SW'(24'hFFFFFF)) ? 24'hFFFFFF : rb[NR][23:0];

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        c2s_cordic_cell #(.STAGE(g)) u_ra (
            .clk(clk), .x_in(xa[g]), .y_in(ya[g]), .a_in(aa[g]),
            .x_out(xa[g+1]), .y_out(ya[g+1]), .a_out(aa[g+1]));
        c2s_cordic_cell #(.STAGE(g)) u_de (
            .clk(clk), .x_in(xd[g]), .y_in(yd[g]), .a_in(ad[g]),
            .x_out(xd[g+1]), .y_out(yd[g+1]), .a_out(ad[g+1]));
        always_ff @(posedge clk)
        begin
            spa[g+1] <= spa[g]; sva[g+1] <= sva[g];
            spd[g+1] <= spd[g]; svd[g+1] <= svd[g];
            cd[g+1]  <= cd[g];  mg[g+1]  <= mg[g];
        end
    end

    // division chain for normalization
    localparam int CS = CORDIC_STAGES;
    logic [DW-1:0] rem [DW+1][3], quo [DW+1][3];
    logic [DW-1:0] den_d [DW+1];
    item_t dv [DW+1];
    logic signed [24:0] rav [DW+1], dev [DW+1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [23:0] c;
            logic [23:0] ab;
            c = (k == 0) ? cd[CS].x : (k == 1) ? cd[CS].y : cd[CS].z;
            ab = c[23] ? 24'(-c) : c;
            // magnitude of c shifted up, plus half the divisor for rounding
            rem[0][k] = (DW'(ab) << FRAC_BITS) + DW'(mg[CS] >> 1);
            quo[0][k] = '0;
        end
    end
    assign den_d[0] = DW'(mg[CS]);
    assign dv[0] = cd[CS];
    assign rav[0] = spa[CS] ? to_frac(sva[CS], 180) : to_frac(aa[CS], 180);
    assign dev[0] = spd[CS] ? to_frac(svd[CS], 90) : to_frac(ad[CS], 90);

    for (genvar g = 0; g < DW; g++)
    begin : g_div
        c2s_div_cell #(.STEP(g)) u_div (
            .clk(clk), .rem_in(rem[g]), .quo_in(quo[g]), .den(den_d[g]),
            .rem_out(rem[g+1]), .quo_out(quo[g+1]));
        always_ff @(posedge clk)
        begin
            den_d[g+1] <= den_d[g];
            dv[g+1] <= dv[g];
            rav[g+1] <= rav[g];
            dev[g+1] <= dev[g];
        end
    end

    function automatic logic signed [23:0] sat(input logic neg, input logic [DW-1:0] q);
        if (!neg)
            return (q > DW'(8388607)) ? 24'sh7FFFFF : q[23:0];
        else
            return (q > DW'(8388608)) ? 24'sh800000 : 24'(-q[23:0]);
    endfunction

    logic do_norm;
    assign do_norm = dv[DW].norm && den_d[DW] != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        right_ascension <= rav[DW];
        declination <= dev[DW][23:0];
        if (do_norm)
        begin
            out_x <= sat(dv[DW].x[23], quo[DW][0]);
            out_y <= sat(dv[DW].y[23], quo[DW][1]);
            out_z <= sat(dv[DW].z[23], quo[DW][2]);
            magnitude <= ((DW'(1) << FRAC_BITS) > DW'(24'hFFFFFF)) ? 24'hFFFFFF
                       : 24'(DW'(1) << FRAC_BITS);
        end
        else
        begin
            out_x <= dv[DW].x;
            out_y <= dv[DW].y;
            out_z <= dv[DW].z;
            magnitude <= den_d[DW][23:0];
        end
    end
endmodule
`default_nettype wire

@@ design/c2s_checker.sv @@
// Port-level checker for the converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module c2s_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [24:0] right_ascension,
    input wire logic signed [23:0] declination,
    input wire logic signed [23:0] out_x,
    input wire logic signed [23:0] out_y,
    input wire logic signed [23:0] out_z,
    input wire logic        [23:0] magnitude
);
    `CHK_IMPLY(a_never_busy, clk, rst_n, 1'b1, !busy)
    `CHK_IMPLY(a_dec_range, clk, rst_n, done,
        declination <= 24'sd5898240 && declination >= -24'sd5898240)
    `CHK_IMPLY(a_ra_range, clk, rst_n, done,
        right_ascension <= 25'sd11796480 && right_ascension >= -25'sd11796480)
    `CHK_IMPLY(a_zero_vec, clk, rst_n, done && magnitude == 0,
        out_x == 0 && out_y == 0 && out_z == 0 && right_ascension == 0)
endmodule
bind cartesian_to_spherical_deg_top c2s_checker u_c2s_checker (.*);
`default_nettype wire

@@ test/cartesian_to_spherical_deg_top_tb.sv @@
// Self-checking testbench for the Cartesian to spherical converter
`timescale 1ns / 1ps
`default_nettype none
module cartesian_to_spherical_deg_top_tb;

    localparam int FRAC = 16;
    localparam int STAGES = 20;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic        [23:0] mag;
        logic signed [24:0] ra;
        logic signed [23:0] dec;
    } sph_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [23:0] vec_x;
    logic signed [23:0] vec_y;
    logic signed [23:0] vec_z;
    logic               normalize;
    logic               done;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic        [23:0] magnitude;
    logic signed [24:0] right_ascension;
    logic signed [23:0] declination;

    sph_t   expected_sph[$];
    longint atan_deg_q32[STAGES];
    int     mismatches;

    cartesian_to_spherical_deg_top i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .normalize(normalize),
        .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .magnitude(magnitude), .right_ascension(right_ascension),
        .declination(declination)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // integer square root, rounded to nearest, ties up
    function automatic longint unsigned isqrt_round(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (s > r)
            r++;
        return r;
    endfunction

    // atan(2^-i) in degrees, Q32, by the odd power series
    function automatic longint atan_stage(input int i);
        longint unsigned k52;
        longint acc;
        longint term;
        int sh;
        k52 = 64'd246083499207 << 20;
        acc = 0;
        if (i == 0)
            return 64'sd45 <<< 32;
        for (int k = 0; k < 32; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh < 60)
            begin
                term = longint'((k52 >> sh) / longint'(2 * k + 1));
                acc = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        return (acc + (64'sd1 <<< 19)) >>> 20;
    endfunction

    // vectoring CORDIC, atan2(num, den) in Q32 degrees
    function automatic longint atan2_deg_q32(input longint num, input longint den);
        longint ang;
        longint xa;
        longint ya;
        longint t;
        longint dx;
        longint dy;
        ang = 0;
        if (num == 0)
            return (den < 0) ? (64'sd180 <<< 32) : 0;
        if (den == 0)
            return (num > 0) ? (64'sd90 <<< 32) : -(64'sd90 <<< 32);
        if (den < 0)
        begin
            t = den;
            if (num > 0)
            begin
                den = num;
                num = -t;
                ang = 64'sd90 <<< 32;
            end
            else
            begin
                den = -num;
                num = t;
                ang = -(64'sd90 <<< 32);
            end
        end
        xa = den <<< 30;
        ya = num <<< 30;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (ya > 0)
            begin
                xa = xa + dx;
                ya = ya - dy;
                ang = ang + atan_deg_q32[i];
            end
            else
            begin
                xa = xa - dx;
                ya = ya + dy;
                ang = ang - atan_deg_q32[i];
            end
        end
        return ang;
    endfunction

    function automatic longint deg_round_clamp(input longint a, input longint lim_deg);
        longint lim;
        longint v;
        lim = lim_deg <<< FRAC;
        v = (a + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic logic signed [23:0] unit_component(input longint c,
                                                          input longint unsigned m);
        longint unsigned u;
        longint q;
        u = longint'(c < 0 ? -c : c) << FRAC;
        q = longint'((u + m / 2) / m);
        if (c < 0)
            q = -q;
        if (q > 8388607)
            q = 8388607;
        if (q < -8388608)
            q = -8388608;
        return q[23:0];
    endfunction

    function automatic sph_t predict_spherical(input logic signed [23:0] x,
                                               input logic signed [23:0] y,
                                               input logic signed [23:0] z,
                                               input logic norm);
        sph_t r;
        longint xl;
        longint yl;
        longint zl;
        longint unsigned sxy;
        longint unsigned len;
        longint unsigned rxy;
        longint ra;
        longint dc;
        xl = x;
        yl = y;
        zl = z;
        sxy = longint'(xl * xl) + longint'(yl * yl);
        len = isqrt_round(sxy + longint'(zl * zl));
        rxy = isqrt_round(sxy);
        ra = deg_round_clamp(atan2_deg_q32(yl, xl), 180);
        dc = deg_round_clamp(atan2_deg_q32(zl, longint'(rxy)), 90);
        r.x = x;
        r.y = y;
        r.z = z;
        r.mag = (len > 64'hFFFFFF) ? 24'hFFFFFF : len[23:0];
        if (norm && len != 0)
        begin
            r.x = unit_component(xl, len);
            r.y = unit_component(yl, len);
            r.z = unit_component(zl, len);
            r.mag = 24'd1 << FRAC;
        end
        r.ra = ra[24:0];
        r.dec = dc[23:0];
        return r;
    endfunction

    // Hold one transaction on the inputs until it is accepted.
    task automatic send_vector(input logic signed [23:0] x, input logic signed [23:0] y,
                               input logic signed [23:0] z, input logic norm);
        @(negedge clk);
        start <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        normalize <= norm;
        do
            @(posedge clk);
        while (busy);
        expected_sph.push_back(predict_spherical(x, y, z, norm));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (expected_sph.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [23:0] random_component(input int mode);
        logic signed [23:0] v;
        case (mode)
            0: v = 24'($urandom);
            1: v = $signed(24'($urandom_range(0, 1023))) - 24'sd512;
            2: v = 24'sd0;
            3: v = ($urandom_range(0, 1) == 1) ? 24'sh7FFFFF : 24'sh800000;
            default: v = $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_vector(0, 0, 0, 1'b1);
        send_vector(0, 0, 0, 1'b0);
        send_vector(24'sd65536, 0, 0, 1'b0);
        send_vector(-24'sd65536, 0, 0, 1'b1);
        send_vector(0, 24'sd65536, 0, 1'b1);
        send_vector(0, -24'sd65536, 0, 1'b0);
        send_vector(0, 0, 24'sd65536, 1'b1);
        send_vector(0, 0, -24'sd65536, 1'b0);
        send_vector(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_vector(24'sh800000, 24'sh800000, 24'sh800000, 1'b1);
        send_vector(24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
        send_vector(24'sh7FFFFF, 24'sh800000, 0, 1'b1);
        send_vector(1, 0, 0, 1'b1);
        send_vector(1, 1, 1, 1'b1);
        send_vector(-1, -1, -1, 1'b1);
        send_vector(-1, 0, 0, 1'b0);
        send_vector(-24'sd3, 24'sd1, 0, 1'b0);
        send_vector(-24'sd3, -24'sd1, 0, 1'b0);
        send_vector(24'sd1000, 24'sd1000, 24'sd1000, 1'b1);
        send_vector(0, 0, 24'sh800000, 1'b1);
        send_vector(24'sh123456, -24'sh0ABCDE, 24'sh3C0F00, 1'b1);
        idle_cycles(3);
    endtask

    task automatic test_random(input int count);
        int sent;
        int burst;
        int mx;
        int my;
        int mz;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                mx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
                my = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
                mz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
                send_vector(random_component(mx), random_component(my),
                            random_component(mz), 1'($urandom));
                sent++;
            end
            // some bursts run back to back with no gap at all
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 9));
            if (sent >= count / 2 && sent - burst < count / 2)
                wait_drained();
        end
        idle_cycles(1);
    endtask

    always @(posedge clk)
    begin
        sph_t e;
        if (rst_n && done)
        begin
            if (expected_sph.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                e = expected_sph.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
                    magnitude !== e.mag || right_ascension !== e.ra ||
                    declination !== e.dec)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: exp %0d %0d %0d m%0d ra%0d dec%0d,",
                                  " got %0d %0d %0d m%0d ra%0d dec%0d"},
                                 $realtime, e.x, e.y, e.z, e.mag, e.ra, e.dec,
                                 out_x, out_y, out_z, magnitude, right_ascension,
                                 declination);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        for (int i = 0; i < STAGES; i++)
            atan_deg_q32[i] = atan_stage(i);
        rst_n = 1'b0;
        start = 1'b0;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        normalize = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(1630);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_sph.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

@@ cartesian_to_spherical_deg_top.f @@
+incdir+design
design/c2s_pkg.sv
design/c2s_root_cell.sv
design/c2s_cordic_cell.sv
design/c2s_div_cell.sv
design/cartesian_to_spherical_deg_top.sv
design/c2s_checker.sv
test/cartesian_to_spherical_deg_top_tb.sv
